/* rtl/lz4_block_decoder_assert.svh */
// Assertion macros shared by the block decoder RTL.
`ifndef LZ4_BLOCK_DECODER_ASSERT_SVH
`define LZ4_BLOCK_DECODER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LZBD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define LZBD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/lzbd_pkg.sv */
// Package with phase codes, error codes and the header magic for the block decoder.
package lzbd_pkg;

  typedef enum logic [3:0] {
    PH_HEADER = 4'd0,
    PH_TOKEN  = 4'd1,
    PH_LITEXT = 4'd2,
    PH_LIT    = 4'd3,
    PH_OFFLO  = 4'd4,
    PH_OFFHI  = 4'd5,
    PH_MATEXT = 4'd6,
    PH_COPY   = 4'd7,
    PH_DRAIN  = 4'd8
  } phase_t;

  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_MAGIC     = 4'd1;
  localparam logic [3:0] ERR_DECL_BIG  = 4'd2;
  localparam logic [3:0] ERR_TRUNC     = 4'd3;
  localparam logic [3:0] ERR_OVER_DECL = 4'd4;
  localparam logic [3:0] ERR_OFFSET    = 4'd5;
  localparam logic [3:0] ERR_LEN_CAP   = 4'd6;
  localparam logic [3:0] ERR_SIZE      = 4'd7;
  localparam logic [3:0] ERR_TOO_LONG  = 4'd8;

  localparam int HIST_AW = 16;
  localparam int HIST_DEPTH = 1 << HIST_AW;
  localparam logic [31:0] SIZE_LIMIT_RESET = 32'd16777216;
  localparam logic [3:0] HEADER_LEN = 4'd12;
  localparam logic [7:0] EXT_BYTE = 8'd255;
  localparam logic [3:0] NIBBLE_EXT = 4'd15;

  // Expected header magic, one byte per position.
  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] m;
    case (idx)
      3'd0: m = 8'h6d;
      3'd1: m = 8'h6f;
      3'd2: m = 8'h7a;
      3'd3: m = 8'h4c;
      3'd4: m = 8'h7a;
      3'd5: m = 8'h34;
      3'd6: m = 8'h30;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

/* rtl/lz4_block_decoder.sv */
// Streaming LZ4 block decoder with a 64 KiB history memory and a registered result stage.
//
//  channel | ports                                     | handshake
//  input   | cmd, data_byte, last_byte                 | in_valid / in_stall
//  result  | accepted, out_valid, out_byte,            | res_valid / res_stall
//          | copy_pending, done_res, error_code        |
//  config  | cfg_data (size_limit)                     | cfg_valid / cfg_ready
//
// One word per cycle in each direction unless stalled; a result is registered from its input word.
// Copy bytes come from the history read issued at acceptance; the prior byte is forwarded.
// Reset (rst, synchronous) returns to the header phase; history is not cleared.
// A stalled result holds the input off through in_stall; no words are lost.
module lz4_block_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        res_valid,
  input  logic        res_stall,
  output logic        accepted,
  output logic        out_valid,
  output logic [7:0]  out_byte,
  output logic        copy_pending,
  output logic        done_res,
  output logic [3:0]  error_code,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  import lzbd_pkg::*;

  // Decoder state.
  logic [31:0] size_limit;
  phase_t      phase, phase_next;
  logic [3:0]  hcnt, hcnt_next;
  logic [31:0] decl, decl_next;
  logic [31:0] ocnt, ocnt_next;
  logic [32:0] icnt, icnt_next;
  logic [31:0] lit_left, lit_left_next;
  logic [31:0] m_left, m_left_next;
  logic [15:0] m_off, m_off_next;
  logic [3:0]  m_nib, m_nib_next;
  logic [3:0]  serr, serr_next;
  logic        fended, fended_next;

  // Result stage and history access.
  logic [7:0]  hist [HIST_DEPTH];
  logic [7:0]  rd_data, fwd_data, lit_byte;
  logic        fwd_hit, from_mem, wr_pend;
  logic [15:0] wr_addr, rd_addr;
  logic [7:0]  cur_byte;

  logic        take;
  logic        c_acc, c_outv, c_copy, c_done;
  logic [3:0]  c_code;
  logic [7:0]  c_lit;
  logic [3:0]  fail_code;
  logic        do_finish, lit_chk, mat_chk;
  logic [32:0] len_sum;
  logic [32:0] lim_ext;

  assign cfg_ready = 1'b1;
  assign in_stall  = res_valid && res_stall;
  assign take      = in_valid && !in_stall;
  assign cur_byte  = from_mem ? (fwd_hit ? fwd_data : rd_data) : lit_byte;
  assign out_byte  = out_valid ? cur_byte : 8'd0;
  assign rd_addr   = ocnt[15:0] - m_off;
  assign lim_ext   = {1'b0, size_limit};

  // Next state and result for one input word.
  always_comb begin
    phase_next = phase; hcnt_next = hcnt; decl_next = decl; ocnt_next = ocnt;
    icnt_next = icnt; lit_left_next = lit_left; m_left_next = m_left;
    m_off_next = m_off; m_nib_next = m_nib; serr_next = serr; fended_next = fended;
    c_acc = 1'b1; c_outv = 1'b0; c_copy = 1'b0; c_done = 1'b0; c_code = ERR_NONE;
    c_lit = 8'd0; fail_code = ERR_NONE; do_finish = 1'b0; lit_chk = 1'b0;
    mat_chk = 1'b0; len_sum = 33'd0;
    if (!cmd) begin
      if (phase == PH_COPY) begin
        c_acc = 1'b0;
      end else if (phase == PH_DRAIN) begin
        do_finish = last_byte;
      end else begin
        icnt_next = icnt + 33'd1;
        if ({1'b0, icnt_next} > {1'b0, lim_ext} + 34'd12) begin
          fail_code = ERR_TOO_LONG;
        end else begin
          case (phase)
            PH_HEADER: begin
              if (!hcnt[3] && data_byte != magic_byte(hcnt[2:0])) begin
                fail_code = ERR_MAGIC;
              end else begin
                if (hcnt[3])
                  decl_next[{hcnt[1:0], 3'b000} +: 8] =
                    decl[{hcnt[1:0], 3'b000} +: 8] | data_byte;
                hcnt_next = hcnt + 4'd1;
                if (hcnt_next >= HEADER_LEN) begin
                  if (decl_next > size_limit) begin
                    fail_code = ERR_DECL_BIG;
                  end else begin
                    phase_next = PH_TOKEN;
                    do_finish = last_byte;
                  end
                end else if (last_byte) begin
                  fail_code = ERR_TRUNC;
                end
              end
            end
            PH_TOKEN: begin
              m_nib_next = data_byte[3:0];
              lit_left_next = {28'd0, data_byte[7:4]};
              if (data_byte[7:4] == NIBBLE_EXT) begin
                if (last_byte) fail_code = ERR_TRUNC;
                else phase_next = PH_LITEXT;
              end else begin
                lit_chk = 1'b1;
              end
            end
            PH_LITEXT: begin
              len_sum = {1'b0, lit_left} + {25'd0, data_byte};
              if (len_sum > lim_ext) begin
                fail_code = ERR_LEN_CAP;
              end else begin
                lit_left_next = len_sum[31:0];
                if (data_byte == EXT_BYTE) begin
                  if (last_byte) fail_code = ERR_TRUNC;
                end else begin
                  lit_chk = 1'b1;
                end
              end
            end
            PH_LIT: begin
              c_outv = 1'b1;
              c_lit = data_byte;
              ocnt_next = ocnt + 32'd1;
              lit_left_next = lit_left - 32'd1;
              if (lit_left_next == 32'd0) begin
                if (last_byte) do_finish = 1'b1;
                else phase_next = PH_OFFLO;
              end else if (last_byte) begin
                fail_code = ERR_TRUNC;
              end
            end
            PH_OFFLO: begin
              m_off_next = {8'd0, data_byte};
              if (last_byte) fail_code = ERR_TRUNC;
              else phase_next = PH_OFFHI;
            end
            PH_OFFHI: begin
              m_off_next = {data_byte, m_off[7:0]};
              if (m_off_next == 16'd0 || {16'd0, m_off_next} > ocnt) begin
                fail_code = ERR_OFFSET;
              end else begin
                m_left_next = {28'd0, m_nib};
                if (m_nib == NIBBLE_EXT) begin
                  if (last_byte) fail_code = ERR_TRUNC;
                  else phase_next = PH_MATEXT;
                end else begin
                  mat_chk = 1'b1;
                end
              end
            end
            PH_MATEXT: begin
              len_sum = {1'b0, m_left} + {25'd0, data_byte};
              if (len_sum > lim_ext) begin
                fail_code = ERR_LEN_CAP;
              end else begin
                m_left_next = len_sum[31:0];
                if (data_byte == EXT_BYTE) begin
                  if (last_byte) fail_code = ERR_TRUNC;
                end else begin
                  mat_chk = 1'b1;
                end
              end
            end
            default: fail_code = ERR_TRUNC;
          endcase
        end
      end
    end else if (phase == PH_COPY) begin
      // One match byte from history.
      c_outv = 1'b1;
      c_copy = 1'b1;
      ocnt_next = ocnt + 32'd1;
      m_left_next = m_left - 32'd1;
      if (m_left_next == 32'd0) begin
        if (fended) do_finish = 1'b1;
        else phase_next = PH_TOKEN;
      end
    end

    // Literal length complete.
    if (lit_chk) begin
      if ({1'b0, ocnt} + {1'b0, lit_left_next} > {1'b0, decl}) begin
        fail_code = ERR_OVER_DECL;
      end else if (lit_left_next == 32'd0) begin
        if (last_byte) do_finish = 1'b1;
        else phase_next = PH_OFFLO;
      end else if (last_byte) begin
        fail_code = ERR_TRUNC;
      end else begin
        phase_next = PH_LIT;
      end
    end

    // Match length complete: add the minimum match of four.
    if (mat_chk) begin
      len_sum = {1'b0, m_left_next} + 33'd4;
      if ({2'b0, ocnt} + {1'b0, len_sum} > {2'b0, decl}) begin
        fail_code = ERR_OVER_DECL;
      end else begin
        m_left_next = len_sum[31:0];
        phase_next = PH_COPY;
        if (last_byte) fended_next = 1'b1;
      end
    end

    // First error moves to drain.
    if (fail_code != ERR_NONE) begin
      serr_next = fail_code;
      phase_next = PH_DRAIN;
      do_finish = last_byte;
    end

    c_code = serr_next;
    if (do_finish) begin
      c_done = 1'b1;
      c_code = (serr_next == ERR_NONE && ocnt_next != decl_next) ? ERR_SIZE : serr_next;
      phase_next = PH_HEADER; hcnt_next = 4'd0; decl_next = 32'd0; ocnt_next = 32'd0;
      icnt_next = 33'd0; lit_left_next = 32'd0; m_left_next = 32'd0; m_off_next = 16'd0;
      m_nib_next = 4'd0; serr_next = ERR_NONE; fended_next = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      size_limit <= SIZE_LIMIT_RESET;
      phase <= PH_HEADER; hcnt <= 4'd0; decl <= 32'd0; ocnt <= 32'd0; icnt <= 33'd0;
      lit_left <= 32'd0; m_left <= 32'd0; m_off <= 16'd0; m_nib <= 4'd0;
      serr <= ERR_NONE; fended <= 1'b0;
      res_valid <= 1'b0; wr_pend <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) size_limit <= cfg_data;
      wr_pend <= take;
      if (take) begin
        phase <= phase_next; hcnt <= hcnt_next; decl <= decl_next; ocnt <= ocnt_next;
        icnt <= icnt_next; lit_left <= lit_left_next; m_left <= m_left_next;
        m_off <= m_off_next; m_nib <= m_nib_next; serr <= serr_next;
        fended <= fended_next;
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Result payload and forwarding of the byte being written this cycle.
  always_ff @(posedge clk) begin
    if (take) begin
      accepted     <= c_acc;
      out_valid    <= c_outv;
      copy_pending <= (phase_next == PH_COPY);
      done_res     <= c_done;
      error_code   <= c_code;
      lit_byte     <= c_lit;
      from_mem     <= c_copy;
      wr_addr      <= ocnt[15:0];
      fwd_hit      <= wr_pend && out_valid && (wr_addr == rd_addr);
      fwd_data     <= cur_byte;
    end
  end

  // History memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_pend && out_valid) hist[wr_addr] <= cur_byte;
    if (take) rd_data <= hist[rd_addr];
  end

`include "lz4_block_decoder_assert.svh"

  `LZBD_ASSERT_NOW(a_stall_needs_result, in_stall, res_valid)
  `LZBD_ASSERT_NOW(a_done_ends_copy, res_valid && done_res, !copy_pending)
  `LZBD_ASSERT_NEXT(a_take_gives_result, take, res_valid)

endmodule
